/* design/calc_pkg.sv */
// ----------------------------------------------------------------------------
// calc_pkg
// shared types, character codes and defaults for the infix calculator
// ----------------------------------------------------------------------------
package calc_pkg;

  localparam int VALUE_BITS_DEF = 48;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH    = 4;

  // ascii codes
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_ADD   = 8'h2B;
  localparam logic [7:0] CH_SUB   = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // pending multiplicative operator
  localparam logic [1:0] MOP_NONE = 2'd0;
  localparam logic [1:0] MOP_MUL  = 2'd1;
  localparam logic [1:0] MOP_DIV  = 2'd2;

  typedef enum logic [2:0] {
    CODE_NONE, CODE_DIGIT, CODE_MUL, CODE_DIV, CODE_ADD, CODE_SUB
  } code_t;

  typedef struct packed {
    code_t      code;
    logic [3:0] digit;
    logic       eol;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FOLD, ST_MUL, ST_DIV, ST_POST, ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    ACT_MUL, ACT_DIV, ACT_ADD, ACT_SUB, ACT_EOL
  } act_t;

endpackage

/* design/calc_front.sv */
// ----------------------------------------------------------------------------
// calc_front
// classifies incoming characters and queues them for the execution unit
// ----------------------------------------------------------------------------
module calc_front #(
  parameter int DEPTH = calc_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_char,
  input  logic            in_eol,
  output logic            out_valid,
  input  logic            out_pop,
  output calc_pkg::item_t out_item
);

  localparam int AW = $clog2(DEPTH);

  calc_pkg::item_t cls;
  calc_pkg::item_t queue [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [AW:0]     count;
  logic            push;
  logic            pop;

  always_comb begin
    cls.digit = in_char[3:0];
    cls.eol   = in_eol;
    priority if (in_char >= calc_pkg::CH_ZERO && in_char <= calc_pkg::CH_NINE) begin
      cls.code = calc_pkg::CODE_DIGIT;
    end else if (in_char == calc_pkg::CH_MUL) begin
      cls.code = calc_pkg::CODE_MUL;
    end else if (in_char == calc_pkg::CH_DIV) begin
      cls.code = calc_pkg::CODE_DIV;
    end else if (in_char == calc_pkg::CH_ADD) begin
      cls.code = calc_pkg::CODE_ADD;
    end else if (in_char == calc_pkg::CH_SUB) begin
      cls.code = calc_pkg::CODE_SUB;
    end else if (in_char == calc_pkg::CH_SPACE) begin
      cls.code = calc_pkg::CODE_NONE;
    end else begin
      cls.code = calc_pkg::CODE_NONE;
    end
  end

  assign in_ready  = (count != (AW+1)'(DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_pop && out_valid;
  assign out_item  = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

/* design/calc_back.sv */
// ----------------------------------------------------------------------------
// calc_back
// executes queued items: operand build, serial multiply and divide, sums
// ----------------------------------------------------------------------------
module calc_back #(
  parameter int VALUE_BITS = calc_pkg::VALUE_BITS_DEF,
  parameter int FRAC_BITS  = calc_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  calc_pkg::item_t       item,
  output logic                  item_pop,
  output logic                  res_valid,
  input  logic                  res_ready,
  output logic [VALUE_BITS-1:0] res_value,
  output logic                  res_dz,
  output logic                  res_ov
);

  localparam int VB = VALUE_BITS;
  localparam int OW = VALUE_BITS - 1 - FRAC_BITS;
  localparam int CW = $clog2(VALUE_BITS + 1);
  localparam logic [VB-1:0] MAXV = {1'b0, {(VB-1){1'b1}}};
  localparam logic [VB-1:0] MINV = {1'b1, {(VB-1){1'b0}}};

  calc_pkg::state_t state, state_next;
  calc_pkg::act_t   act;
  logic             eol_pend;
  logic [VB-1:0]    sum;
  logic [VB-1:0]    term;
  logic [OW-1:0]    operand;
  logic [1:0]       mulop;
  logic             sign;
  logic             dz;
  logic             ov;
  logic [VB+1:0]    acc;
  logic [VB-1:0]    mt;
  logic [OW-1:0]    opr;
  logic [OW-1:0]    rem;
  logic             neg;
  logic             sticky;
  logic [CW-1:0]    cnt;

  logic [OW+3:0] dig_val;
  logic          dig_ovf;
  logic [VB:0]   s_ext;
  logic          sum_ovf;
  logic [VB-1:0] sum_sat;
  logic          t_neg;
  logic [VB-1:0] t_mag;
  logic [VB+1:0] acc_step;
  logic [VB+1:0] lim;
  logic          mul_ovf;
  logic [OW:0]   rem_sh;
  logic [OW:0]   rem_sub;
  logic          ge;

  function automatic logic [VB-1:0] apply_sign(input logic [VB-1:0] m, input logic n);
    apply_sign = n ? (~m + 1'b1) : m;
  endfunction

  // operand * 10 + digit, saturating at the integer limit
  always_comb begin
    dig_val = ({4'b0, operand} << 3) + ({4'b0, operand} << 1) + (OW+4)'(item.digit);
    dig_ovf = dig_val > {4'b0, {OW{1'b1}}};
  end

  always_comb begin
    if (sign) s_ext = {sum[VB-1], sum} - {term[VB-1], term};
    else      s_ext = {sum[VB-1], sum} + {term[VB-1], term};
    sum_ovf = s_ext[VB] != s_ext[VB-1];
    sum_sat = sum_ovf ? (s_ext[VB] ? MINV : MAXV) : s_ext[VB-1:0];
  end

  always_comb begin
    t_neg    = term[VB-1];
    t_mag    = t_neg ? (~term + 1'b1) : term;
    acc_step = {acc[VB:0], 1'b0} + (opr[OW-1] ? {2'b0, mt} : '0);
    lim      = {2'b0, (neg ? MINV : MAXV)};
    mul_ovf  = sticky || (acc_step > lim);
    rem_sh   = {rem, mt[VB-1]};
    ge       = rem_sh >= {1'b0, opr};
    rem_sub  = rem_sh - {1'b0, opr};
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      calc_pkg::ST_IDLE: begin
        if (item_valid) begin
          unique case (item.code)
            calc_pkg::CODE_DIGIT,
            calc_pkg::CODE_NONE: state_next = item.eol ? calc_pkg::ST_FOLD : calc_pkg::ST_IDLE;
            default:             state_next = calc_pkg::ST_FOLD;
          endcase
        end
      end
      calc_pkg::ST_FOLD: begin
        if (mulop == calc_pkg::MOP_MUL) state_next = calc_pkg::ST_MUL;
        else if (mulop == calc_pkg::MOP_DIV && operand != '0) state_next = calc_pkg::ST_DIV;
        else state_next = calc_pkg::ST_POST;
      end
      calc_pkg::ST_MUL: begin
        if (cnt == CW'(OW-1)) state_next = calc_pkg::ST_POST;
      end
      calc_pkg::ST_DIV: begin
        if (cnt == CW'(VB-1)) state_next = calc_pkg::ST_POST;
      end
      calc_pkg::ST_POST: begin
        if (act == calc_pkg::ACT_EOL) state_next = calc_pkg::ST_OUT;
        else state_next = eol_pend ? calc_pkg::ST_FOLD : calc_pkg::ST_IDLE;
      end
      calc_pkg::ST_OUT: begin
        if (!res_valid || res_ready) state_next = calc_pkg::ST_IDLE;
      end
      default: state_next = calc_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    item_pop = (state == calc_pkg::ST_IDLE) && item_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= calc_pkg::ST_IDLE;
      res_valid <= 1'b0;
      sum       <= '0;
      term      <= '0;
      operand   <= '0;
      mulop     <= calc_pkg::MOP_NONE;
      sign      <= 1'b0;
      dz        <= 1'b0;
      ov        <= 1'b0;
      act       <= calc_pkg::ACT_EOL;
      eol_pend  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == calc_pkg::ST_OUT && (!res_valid || res_ready)) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
      unique case (state)
        calc_pkg::ST_IDLE: begin
          if (item_valid) begin
            eol_pend <= item.eol;
            unique case (item.code)
              calc_pkg::CODE_MUL: act <= calc_pkg::ACT_MUL;
              calc_pkg::CODE_DIV: act <= calc_pkg::ACT_DIV;
              calc_pkg::CODE_ADD: act <= calc_pkg::ACT_ADD;
              calc_pkg::CODE_SUB: act <= calc_pkg::ACT_SUB;
              default:            act <= calc_pkg::ACT_EOL;
            endcase
            if (item.code == calc_pkg::CODE_DIGIT) begin
              if (dig_ovf) begin
                operand <= {OW{1'b1}};
                ov      <= 1'b1;
              end else begin
                operand <= dig_val[OW-1:0];
              end
            end
          end
        end
        calc_pkg::ST_FOLD: begin
          operand <= '0;
          cnt     <= '0;
          neg     <= t_neg;
          mt      <= t_mag;
          opr     <= operand;
          acc     <= '0;
          sticky  <= 1'b0;
          rem     <= '0;
          if (mulop == calc_pkg::MOP_DIV) begin
            if (operand == '0) begin
              dz   <= 1'b1;
              term <= t_neg ? MINV : ((term != '0) ? MAXV : '0);
            end
          end else if (mulop != calc_pkg::MOP_MUL) begin
            term <= {1'b0, operand, {FRAC_BITS{1'b0}}};
          end
        end
        calc_pkg::ST_MUL: begin
          cnt <= cnt + 1'b1;
          opr <= opr << 1;
          if (mul_ovf) sticky <= 1'b1;
          else acc <= acc_step;
          if (cnt == CW'(OW-1)) begin
            if (mul_ovf) begin
              term <= neg ? MINV : MAXV;
              ov   <= 1'b1;
            end else begin
              term <= apply_sign(acc_step[VB-1:0], neg);
            end
          end
        end
        calc_pkg::ST_DIV: begin
          cnt <= cnt + 1'b1;
          mt  <= {mt[VB-2:0], ge};
          rem <= ge ? rem_sub[OW-1:0] : rem_sh[OW-1:0];
          if (cnt == CW'(VB-1)) begin
            term <= apply_sign({mt[VB-2:0], ge}, neg);
          end
        end
        calc_pkg::ST_POST: begin
          unique case (act)
            calc_pkg::ACT_MUL: mulop <= calc_pkg::MOP_MUL;
            calc_pkg::ACT_DIV: mulop <= calc_pkg::MOP_DIV;
            default: begin
              sum   <= sum_sat;
              if (sum_ovf) ov <= 1'b1;
              term  <= '0;
              mulop <= calc_pkg::MOP_NONE;
              sign  <= (act == calc_pkg::ACT_SUB);
            end
          endcase
          if (eol_pend && act != calc_pkg::ACT_EOL) act <= calc_pkg::ACT_EOL;
        end
        calc_pkg::ST_OUT: begin
          if (!res_valid || res_ready) begin
            res_value <= sum;
            res_dz    <= dz;
            res_ov    <= ov;
            sum       <= '0;
            term      <= '0;
            operand   <= '0;
            mulop     <= calc_pkg::MOP_NONE;
            sign      <= 1'b0;
            dz        <= 1'b0;
            ov        <= 1'b0;
            eol_pend  <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* design/infix_four_op_calculator.sv */
// ----------------------------------------------------------------------------
// infix_four_op_calculator
// one ascii character per transfer, evaluates + - * / lines in fixed point
// ----------------------------------------------------------------------------
// Characters enter on the s_ side, one per transfer; tlast marks the last
// character of a line. Digits build a decimal operand, * and / bind tighter
// than + and -, everything evaluates left to right, spaces and unknown
// characters are ignored. After the last character one result transfer
// appears on the m_ side: the value in signed fixed point (FRAC_BITS fraction
// bits) with divide-by-zero and saturation flags. A four-entry queue sits in
// front of the execution unit, so input keeps flowing while it works and while
// a result waits, until the queue is full. In the execution unit digits,
// spaces and unknown characters are taken in the idle state alone, and + -
// pass through a fold and a sum step; an operator closing a multiply also
// runs the serial shift-add multiplier; one closing a divide runs the
// restoring divider, one quotient bit per cycle; a divide by zero skips it.
// The end of a line runs the same final fold and sum, then a state that loads
// the output register; an operator that ends a line adds a second fold.
// ----------------------------------------------------------------------------
module infix_four_op_calculator #(
  parameter int VALUE_BITS = calc_pkg::VALUE_BITS_DEF,
  parameter int FRAC_BITS  = calc_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,   // character
  input  logic                               s_tlast,   // end_of_line
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // value, divide_by_zero, overflowed, zero fill to bytes
  output logic [((VALUE_BITS+2+7)/8)*8-1:0]  m_tdata
);

  localparam int OUT_W = ((VALUE_BITS + 2 + 7) / 8) * 8;

  calc_pkg::item_t       item;
  logic                  item_valid;
  logic                  item_pop;
  logic [VALUE_BITS-1:0] value;
  logic                  divide_by_zero;
  logic                  overflowed;

  // front: classify and queue
  calc_front #(
    .DEPTH (calc_pkg::QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_char   (s_tdata),
    .in_eol    (s_tlast),
    .out_valid (item_valid),
    .out_pop   (item_pop),
    .out_item  (item)
  );

  // back: arithmetic and the output register
  calc_back #(
    .VALUE_BITS (VALUE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .res_value  (value),
    .res_dz     (divide_by_zero),
    .res_ov     (overflowed)
  );

  assign m_tdata = OUT_W'({overflowed, divide_by_zero, value});

endmodule

/* design/calc_checker.sv */
// ----------------------------------------------------------------------------
// calc_checker
// port-level checks of the calculator, bound to the top level
// ----------------------------------------------------------------------------
module calc_port_checks #(
  parameter int VALUE_BITS = calc_pkg::VALUE_BITS_DEF
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [((VALUE_BITS+2+7)/8)*8-1:0] m_tdata
);

  // result holds while stalled
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  // no result straight out of reset
  a_reset_out: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // queue empty after reset, so input is taken
  a_reset_in: assert property (@(posedge clk)
    rst |=> s_tready)
    else $error("input not ready after reset");

endmodule

bind infix_four_op_calculator calc_port_checks #(
  .VALUE_BITS (VALUE_BITS)
) u_calc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* bench/calc_checker.sv */
// ----------------------------------------------------------------------------
// calc_checker
// watches both streams of the calculator, predicts each line result, compares
// ----------------------------------------------------------------------------
module calc_checker #(
  parameter int VALUE_BITS = calc_pkg::VALUE_BITS_DEF,
  parameter int FRAC_BITS  = calc_pkg::FRAC_BITS_DEF,
  parameter int OUT_W      = ((VALUE_BITS+2+7)/8)*8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [7:0]       s_tdata,
  input  logic             s_tlast,
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [OUT_W-1:0] m_tdata,
  output int               fail_count,
  output int               lines_waiting
);

  localparam longint MAXV  = (64'sd1 <<< (VALUE_BITS-1)) - 1;
  localparam longint MINV  = -MAXV - 1;
  localparam longint OPMAX = MAXV >>> FRAC_BITS;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  dbz;
    logic                  ovf;
  } line_result_t;

  line_result_t line_results[$];

  longint     sum_acc = 0;
  longint     term_acc = 0;
  longint     operand = 0;
  logic [1:0] mul_op = calc_pkg::MOP_NONE;
  logic       minus = 1'b0;
  logic       dbz_mark = 1'b0;
  logic       ovf_mark = 1'b0;
  int         fails = 0;
  int         pending = 0;

  assign fail_count    = fails;
  assign lines_waiting = pending;

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  // saturating signed add of the term (or subtract when sub set)
  task automatic acc_term(input logic sub);
    longint r;
    r = sub ? sum_acc - term_acc : sum_acc + term_acc;
    if (r > MAXV) begin
      r = MAXV;
      ovf_mark = 1'b1;
    end else if (r < MINV) begin
      r = MINV;
      ovf_mark = 1'b1;
    end
    sum_acc = r;
  endtask

  task automatic fold;
    longint m, lim;
    logic   neg;
    neg = term_acc < 0;
    m   = mag(term_acc);
    if (mul_op == calc_pkg::MOP_MUL) begin
      lim = neg ? MAXV + 1 : MAXV;
      if (operand != 0 && m > lim / operand) begin
        ovf_mark = 1'b1;
        term_acc = neg ? MINV : MAXV;
      end else begin
        term_acc = neg ? -(m * operand) : m * operand;
      end
    end else if (mul_op == calc_pkg::MOP_DIV) begin
      if (operand == 0) begin
        dbz_mark = 1'b1;
        term_acc = (term_acc > 0) ? MAXV : (term_acc < 0) ? MINV : 0;
      end else begin
        term_acc = neg ? -(m / operand) : m / operand;
      end
    end else begin
      term_acc = operand <<< FRAC_BITS;
    end
    operand = 0;
  endtask

  task automatic close_term;
    fold();
    acc_term(minus);
    term_acc = 0;
    mul_op   = calc_pkg::MOP_NONE;
  endtask

  task automatic clear_line;
    sum_acc = 0; term_acc = 0; operand = 0;
    mul_op = calc_pkg::MOP_NONE; minus = 1'b0; dbz_mark = 1'b0; ovf_mark = 1'b0;
  endtask

  task automatic take_char(input logic [7:0] c, input logic eol);
    line_result_t r;
    longint d;
    if (c >= calc_pkg::CH_ZERO && c <= calc_pkg::CH_NINE) begin
      d = longint'(c) - longint'(calc_pkg::CH_ZERO);
      if (operand > (OPMAX - d) / 10) begin
        operand  = OPMAX;
        ovf_mark = 1'b1;
      end else begin
        operand = operand * 10 + d;
      end
    end else if (c == calc_pkg::CH_MUL || c == calc_pkg::CH_DIV) begin
      fold();
      mul_op = (c == calc_pkg::CH_MUL) ? calc_pkg::MOP_MUL : calc_pkg::MOP_DIV;
    end else if (c == calc_pkg::CH_ADD || c == calc_pkg::CH_SUB) begin
      close_term();
      minus = (c == calc_pkg::CH_SUB);
    end
    if (eol) begin
      close_term();
      r.value = sum_acc[VALUE_BITS-1:0];
      r.dbz   = dbz_mark;
      r.ovf   = ovf_mark;
      line_results.push_back(r);
      clear_line();
    end
  endtask

  always @(posedge clk) begin
    line_result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) take_char(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        if (line_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time, m_tdata);
          fails++;
        end else begin
          want = line_results.pop_front();
          if (m_tdata[VALUE_BITS-1:0] !== want.value) begin
            $display("%0t: value expected %h actual %h", $time, want.value,
                     m_tdata[VALUE_BITS-1:0]);
            fails++;
          end
          if (m_tdata[VALUE_BITS] !== want.dbz) begin
            $display("%0t: divide_by_zero expected %b actual %b", $time, want.dbz,
                     m_tdata[VALUE_BITS]);
            fails++;
          end
          if (m_tdata[VALUE_BITS+1] !== want.ovf) begin
            $display("%0t: overflowed expected %b actual %b", $time, want.ovf,
                     m_tdata[VALUE_BITS+1]);
            fails++;
          end
        end
      end
    end
    pending = line_results.size();
  end

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the infix calculator
// ----------------------------------------------------------------------------
// Sends directed lines (extremes, every operator, missing operands, long
// operands, saturation, zero divisors, empty lines, unknown characters), then
// random well-formed lines mixed with noise. Both sides idle at random; one
// long receiver hold-off and one drain pause are included.
// ----------------------------------------------------------------------------
module testbench;

  localparam int OUT_W = ((calc_pkg::VALUE_BITS_DEF+2+7)/8)*8;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [7:0]       s_tdata = '0;
  logic             s_tlast = 1'b0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  int               fail_count, lines_waiting;
  logic             hold_off = 1'b0;
  int               chars_sent = 0;
  int               rx_wait = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  infix_four_op_calculator dut (.*);

  calc_checker checker_i (.*);

  // one character per transfer, with random gaps
  task automatic send_char(input logic [7:0] c, input logic eol);
    int gap;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= eol;
    do @(posedge clk); while (!s_tready);
    chars_sent++;
  endtask

  // stop offering input
  task automatic pause_input;
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_line(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 3))
      0: return calc_pkg::CH_ADD;
      1: return calc_pkg::CH_SUB;
      2: return calc_pkg::CH_MUL;
      default: return calc_pkg::CH_DIV;
    endcase
  endfunction

  // random line: mostly well formed, sometimes noisy or broken
  task automatic send_random_line;
    int terms, ndig;
    logic [7:0] c;
    logic noisy;
    noisy = ($urandom_range(0, 7) == 0);
    terms = $urandom_range(1, 5);
    for (int t = 0; t < terms; t++) begin
      if (t != 0 || $urandom_range(0, 5) == 0) send_char(pick_op(), 1'b0);
      if ($urandom_range(0, 4) == 0) send_char(calc_pkg::CH_SPACE, 1'b0);
      ndig = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 16) : $urandom_range(0, 3);
      if (ndig == 0 && $urandom_range(0, 2) != 0) ndig = 1;
      for (int d = 0; d < ndig; d++) begin
        c = calc_pkg::CH_ZERO + 8'($urandom_range(0, 9));
        send_char(c, 1'b0);
      end
      if (noisy) send_char(8'($urandom_range(0, 255)), 1'b0);
    end
    if (noisy) c = 8'($urandom_range(0, 255));
    else c = calc_pkg::CH_ZERO + 8'($urandom_range(0, 9));
    send_char(c, 1'b1);
  endtask

  // receiver: draws a random rx_wait countdown per result, plus one long hold-off
  always @(posedge clk) begin
    if (rst || hold_off) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) rx_wait = $urandom_range(0, 4);
      else if (rx_wait > 0) rx_wait = rx_wait - 1;
      m_tready <= (rx_wait == 0);
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_line("0");
    send_line("9");
    send_line(" ");
    send_line("1+2*3-4/2");
    send_line("-5");
    send_line("3*-2");
    send_line("7/0");
    send_line("-7/0");
    send_line("0/0");
    send_line("99999999999999999");
    send_line("2147483647*2147483647");
    send_line("2147483647+2147483647");
    send_line("-2147483647-2147483647-9");
    send_line("1/3");
    send_line("-1/3*3");
    send_line("8-3-2");
    send_line("12 a* 3x");
    send_line("++--**//");
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b1);
    send_char(8'h55, 1'b1);
    send_char(8'hAA, 1'b1);
    for (int n = 0; chars_sent < 1500; n++) begin
      if (n == 40) begin
        // long receiver hold-off while characters keep coming
        fork
          begin
            hold_off = 1'b1;
            repeat (600) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      if (n == 120) begin
        pause_input();
        wait (lines_waiting == 0);
        repeat (200) @(posedge clk);
      end
      send_random_line();
    end
    pause_input();
    wait (lines_waiting == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && lines_waiting == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* files.f */
design/calc_pkg.sv
design/calc_front.sv
design/calc_back.sv
design/infix_four_op_calculator.sv
design/calc_checker.sv
bench/calc_checker.sv
bench/testbench.sv
